### hw/rtl/espool_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package espool_pkg;

  // Default sizes handed to the top level.
  localparam int POOL_SLOTS_DEF   = 256;
  localparam int FAMILY_COUNT_DEF = 16;
  localparam int MAX_REPORT_DEF   = 64;

  // Operation codes.
  localparam logic [2:0] OP_CREATE     = 3'd0;
  localparam logic [2:0] OP_FIND       = 3'd1;
  localparam logic [2:0] OP_REMOVE     = 3'd2;
  localparam logic [2:0] OP_REMOVE_ALL = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;
  localparam logic [2:0] OP_SET_COMP   = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_MATCH = 2'd2;

  // One input transaction.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  slot_index;
    logic [31:0] search_guid;
    logic [15:0] required_mask;
    logic [6:0]  report_limit;
    logic [3:0]  family_index;
    logic        family_present;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  result_slot;
    logic [31:0] result_guid;
    logic [6:0]  match_count;
    logic        last_result;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEEK,
    S_QUERY,
    S_QLAST,
    S_RMW_RD,
    S_RMW_WR,
    S_WIPE
  } state_t;

  // What the datapath places in the result register.
  typedef enum logic [1:0] {
    EMIT_NOP,
    EMIT_HIT,
    EMIT_PEND,
    EMIT_NONE
  } emit_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic  load;
    logic  wipe;
    logic  scan;
    logic  rmw_rd;
    logic  commit;
    logic  qhit;
    emit_t emit;
    logic  emit_last;
  } ctl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic hit;
    logic last_slot;
    logic ctr_last;
    logic pend;
    logic lim_hit;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/espool_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module espool_dp #(
  parameter int POOL_SLOTS   = espool_pkg::POOL_SLOTS_DEF,
  parameter int FAMILY_COUNT = espool_pkg::FAMILY_COUNT_DEF,
  parameter int MAX_REPORT   = espool_pkg::MAX_REPORT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire espool_pkg::in_item_t in_item,
  input  wire espool_pkg::ctl_cmd_t cmd,
  output espool_pkg::dp_stat_t      stat,
  output logic                      out_valid,
  output espool_pkg::out_item_t     out_item
);

  localparam int SLOT_AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int ENTRY_W = 1 + 32 + FAMILY_COUNT;
  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(POOL_SLOTS - 1);

  // Slot table: used flag, guid and family mask per entry.
  logic [ENTRY_W-1:0] mem [POOL_SLOTS];

  espool_pkg::in_item_t  item_r;
  logic [6:0]            lim_r;
  logic [SLOT_AW-1:0]    ctr_r;
  logic                  dv_r;
  logic [SLOT_AW-1:0]    da_r;
  logic [ENTRY_W-1:0]    rd_data_r;
  logic [6:0]            cnt_r;
  logic [SLOT_AW-1:0]    pend_slot_r;
  logic [31:0]           pend_guid_r;
  logic [31:0]           next_guid_r;
  logic [31:0]           next_guid_nxt;
  logic                  out_valid_r;
  espool_pkg::out_item_t out_item_r;
  espool_pkg::out_item_t out_item_nxt;

  logic                    rd_en;
  logic [SLOT_AW-1:0]      rd_addr;
  logic                    wr_en;
  logic [SLOT_AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0]      wr_data;
  logic                    rd_used;
  logic [31:0]             rd_guid;
  logic [FAMILY_COUNT-1:0] rd_mask;
  logic [15:0]             held;
  logic [FAMILY_COUNT-1:0] fam_sel;
  logic [FAMILY_COUNT-1:0] new_mask;
  logic                    idx_ok;
  logic                    fam_ok;
  logic [SLOT_AW-1:0]      idx_addr;
  logic                    mask_match;
  logic                    hit;
  logic [6:0]              lim_nxt;

  assign rd_used  = rd_data_r[ENTRY_W-1];
  assign rd_guid  = rd_data_r[ENTRY_W-2 -: 32];
  assign rd_mask  = rd_data_r[FAMILY_COUNT-1:0];
  assign idx_ok   = (32'(item_r.slot_index) < POOL_SLOTS);
  assign fam_ok   = (32'(item_r.family_index) < FAMILY_COUNT);
  assign idx_addr = SLOT_AW'(item_r.slot_index);

  // Families held, seen on the 16-bit width of the required mask.
  for (genvar j = 0; j < 16; j++) begin : g_held
    if (j < FAMILY_COUNT) begin : g_in
      assign held[j] = rd_mask[j];
    end else begin : g_out
      assign held[j] = 1'b0;
    end
  end

  // One-hot select of the family written by set component.
  for (genvar j = 0; j < FAMILY_COUNT; j++) begin : g_sel
    assign fam_sel[j] = (32'(item_r.family_index) == j);
  end

  assign new_mask   = item_r.family_present ? (rd_mask | fam_sel) : (rd_mask & ~fam_sel);
  assign mask_match = ((held & item_r.required_mask) == item_r.required_mask);

  // Entry test for the operation in progress.
  always_comb begin
    hit = 1'b0;
    case (item_r.opcode)
      espool_pkg::OP_CREATE:   hit = !rd_used;
      espool_pkg::OP_FIND:     hit = rd_used && (rd_guid == item_r.search_guid);
      espool_pkg::OP_QUERY:    hit = rd_used && mask_match;
      espool_pkg::OP_REMOVE:   hit = rd_used && idx_ok;
      espool_pkg::OP_SET_COMP: hit = rd_used && idx_ok && fam_ok;
      default:                 hit = 1'b0;
    endcase
  end

  assign stat.hit       = dv_r && hit;
  assign stat.last_slot = dv_r && (da_r == LAST_SLOT);
  assign stat.ctr_last  = (ctr_r == LAST_SLOT);
  assign stat.pend      = (cnt_r != 7'd0);
  assign stat.lim_hit   = ((cnt_r + 7'd1) == lim_r);

  // Query limit: zero counts as one, large values are capped.
  always_comb begin
    if (in_item.report_limit == 7'd0) begin
      lim_nxt = 7'd1;
    end else if (32'(in_item.report_limit) > MAX_REPORT) begin
      lim_nxt = 7'(MAX_REPORT);
    end else begin
      lim_nxt = in_item.report_limit;
    end
  end

  // Memory port control.
  assign rd_en   = cmd.scan || cmd.rmw_rd;
  assign rd_addr = cmd.rmw_rd ? idx_addr : ctr_r;
  assign wr_en   = cmd.wipe || (cmd.commit && (item_r.opcode != espool_pkg::OP_FIND));
  assign wr_addr = cmd.wipe ? ctr_r : da_r;

  always_comb begin
    wr_data = '0;
    if (!cmd.wipe) begin
      case (item_r.opcode)
        espool_pkg::OP_CREATE:   wr_data = {1'b1, next_guid_r, {FAMILY_COUNT{1'b0}}};
        espool_pkg::OP_SET_COMP: wr_data = {1'b1, rd_guid, new_mask};
        default:                 wr_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Guid counter wraps and skips zero.
  always_comb begin
    next_guid_nxt = next_guid_r + 32'd1;
    if (next_guid_nxt == 32'd0) begin
      next_guid_nxt = 32'd1;
    end
  end

  // Result register contents.
  always_comb begin
    out_item_nxt = '0;
    case (cmd.emit)
      espool_pkg::EMIT_HIT: begin
        out_item_nxt.status      = espool_pkg::ST_OK;
        out_item_nxt.result_slot = 8'(da_r);
        out_item_nxt.result_guid = (item_r.opcode == espool_pkg::OP_CREATE) ?
                                   next_guid_r : rd_guid;
        out_item_nxt.last_result = 1'b1;
      end
      espool_pkg::EMIT_PEND: begin
        out_item_nxt.status      = espool_pkg::ST_OK;
        out_item_nxt.result_slot = 8'(pend_slot_r);
        out_item_nxt.result_guid = pend_guid_r;
        out_item_nxt.match_count = cnt_r;
        out_item_nxt.last_result = cmd.emit_last;
      end
      espool_pkg::EMIT_NONE: begin
        if (item_r.opcode == espool_pkg::OP_CREATE) begin
          out_item_nxt.status = espool_pkg::ST_FULL;
        end else if (item_r.opcode == espool_pkg::OP_REMOVE_ALL) begin
          out_item_nxt.status = espool_pkg::ST_OK;
        end else begin
          out_item_nxt.status = espool_pkg::ST_NO_MATCH;
        end
        out_item_nxt.last_result = 1'b1;
      end
      default: out_item_nxt = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r       <= '0;
      dv_r        <= 1'b0;
      cnt_r       <= '0;
      next_guid_r <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != espool_pkg::EMIT_NOP);
      if (cmd.load) begin
        ctr_r <= '0;
        dv_r  <= 1'b0;
        cnt_r <= '0;
      end else begin
        if ((cmd.scan || cmd.wipe) && (ctr_r != LAST_SLOT)) begin
          ctr_r <= ctr_r + SLOT_AW'(1);
        end
        if (rd_en) begin
          dv_r <= 1'b1;
        end
        if (cmd.qhit) begin
          cnt_r <= cnt_r + 7'd1;
        end
      end
      if (cmd.commit && (item_r.opcode == espool_pkg::OP_CREATE)) begin
        next_guid_r <= next_guid_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      lim_r  <= lim_nxt;
    end
    if (rd_en) begin
      da_r <= rd_addr;
    end
    if (cmd.qhit) begin
      pend_slot_r <= da_r;
      pend_guid_r <= rd_guid;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### hw/rtl/espool_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module espool_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [2:0]           opcode,
  input  wire espool_pkg::dp_stat_t stat,
  output logic                      busy,
  output espool_pkg::ctl_cmd_t      cmd
);

  espool_pkg::state_t state_r;
  espool_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= espool_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      espool_pkg::S_CLEAR: begin
        if (stat.ctr_last) state_nxt = espool_pkg::S_IDLE;
      end
      espool_pkg::S_IDLE: begin
        if (start) begin
          case (opcode)
            espool_pkg::OP_CREATE, espool_pkg::OP_FIND: state_nxt = espool_pkg::S_SEEK;
            espool_pkg::OP_QUERY:                       state_nxt = espool_pkg::S_QUERY;
            espool_pkg::OP_REMOVE, espool_pkg::OP_SET_COMP: begin
              state_nxt = espool_pkg::S_RMW_RD;
            end
            espool_pkg::OP_REMOVE_ALL:                  state_nxt = espool_pkg::S_WIPE;
            default:                                    state_nxt = espool_pkg::S_QLAST;
          endcase
        end
      end
      espool_pkg::S_SEEK: begin
        if (stat.hit || stat.last_slot) state_nxt = espool_pkg::S_IDLE;
      end
      espool_pkg::S_QUERY: begin
        if (stat.hit) begin
          if (stat.lim_hit || stat.last_slot) state_nxt = espool_pkg::S_QLAST;
        end else if (stat.last_slot) begin
          state_nxt = stat.pend ? espool_pkg::S_QLAST : espool_pkg::S_IDLE;
        end
      end
      espool_pkg::S_QLAST:  state_nxt = espool_pkg::S_IDLE;
      espool_pkg::S_RMW_RD: state_nxt = espool_pkg::S_RMW_WR;
      espool_pkg::S_RMW_WR: state_nxt = espool_pkg::S_IDLE;
      espool_pkg::S_WIPE: begin
        if (stat.ctr_last) state_nxt = espool_pkg::S_QLAST;
      end
      default: state_nxt = espool_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      espool_pkg::S_CLEAR: cmd.wipe = 1'b1;
      espool_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      espool_pkg::S_SEEK: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          cmd.commit = 1'b1;
          cmd.emit   = espool_pkg::EMIT_HIT;
        end else if (stat.last_slot) begin
          cmd.emit = espool_pkg::EMIT_NONE;
        end
      end
      espool_pkg::S_QUERY: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          cmd.qhit = 1'b1;
          if (stat.pend) cmd.emit = espool_pkg::EMIT_PEND;
        end else if (stat.last_slot && !stat.pend) begin
          cmd.emit = espool_pkg::EMIT_NONE;
        end
      end
      espool_pkg::S_QLAST: begin
        // Last pending match of a query, or the single reply of remove all and of unknown opcodes.
        if (stat.pend) begin
          cmd.emit      = espool_pkg::EMIT_PEND;
          cmd.emit_last = 1'b1;
        end else begin
          cmd.emit = espool_pkg::EMIT_NONE;
        end
      end
      espool_pkg::S_RMW_RD: cmd.rmw_rd = 1'b1;
      espool_pkg::S_RMW_WR: begin
        if (stat.hit) begin
          cmd.commit = 1'b1;
          cmd.emit   = espool_pkg::EMIT_HIT;
        end else begin
          cmd.emit = espool_pkg::EMIT_NONE;
        end
      end
      espool_pkg::S_WIPE: cmd.wipe = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/entity_slot_pool_with_mask_query.sv
// Create and find scan the table one slot per cycle from slot 0 until a hit or the last slot;
// a query scans the slots until its report limit is reached or the last slot; remove and set
// component read and then write the one indexed slot; remove all wipes every slot.
// Throughput: one transaction at a time; busy drops in the cycle of the final result, so the
// next start is taken at that edge. The single table read port sets the scan rate.
// Reset: a clearing pass over every slot with busy high; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module entity_slot_pool_with_mask_query #(
  parameter int POOL_SLOTS   = espool_pkg::POOL_SLOTS_DEF,
  parameter int FAMILY_COUNT = espool_pkg::FAMILY_COUNT_DEF,
  parameter int MAX_REPORT   = espool_pkg::MAX_REPORT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire espool_pkg::in_item_t in_item,
  output logic                      out_valid,
  output espool_pkg::out_item_t     out_item
);

  espool_pkg::ctl_cmd_t cmd;
  espool_pkg::dp_stat_t stat;

  // Sequencer for each operation.
  espool_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_item.opcode),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Slot table, counters and result register.
  espool_dp #(
    .POOL_SLOTS   (POOL_SLOTS),
    .FAMILY_COUNT (FAMILY_COUNT),
    .MAX_REPORT   (MAX_REPORT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
